FILE: sv/emfd_pkg.sv
// ----------------------------------------------------------------------------
// Energy meter frame descrambler: shared package
// Byte types, frame view and result structures, and the fixed constants of
// the frame format.
// ----------------------------------------------------------------------------
package emfd_pkg;

    typedef logic [7:0] byte_t;

    localparam int HDR_BYTES = 18;

    localparam byte_t       SALT_INIT     = 8'h89;
    localparam byte_t       SALT_STEP     = 8'h24;
    localparam byte_t       TAIL_MASK     = 8'hFF;
    localparam logic [15:0] RES_FIRST     = 16'hF00F;
    localparam logic [15:0] RES_SECOND    = 16'hEE11;
    localparam byte_t       SUBTYPE_ONE   = 8'h01;
    localparam byte_t       SUBTYPE_THREE = 8'h03;
    localparam logic [4:0]  LEN_SHORT     = 5'd18;
    localparam logic [4:0]  LEN_LONG      = 5'd20;

    localparam logic [2:0] KIND_BAD_LEN    = 3'd0;
    localparam logic [2:0] KIND_BAD_SUM    = 3'd1;
    localparam logic [2:0] KIND_FIRST_ONE  = 3'd2;
    localparam logic [2:0] KIND_FIRST_THREE = 3'd3;
    localparam logic [2:0] KIND_FIRST_OTHER = 3'd4;
    localparam logic [2:0] KIND_SECOND     = 3'd5;

    typedef struct packed {
        byte_t [HDR_BYTES-1:0] hdr;
        byte_t                 chk_hi;
        byte_t                 chk_lo;
        logic [15:0]           byte_sum;
        logic                  length_ok;
    } frame_view_t;

    typedef struct packed {
        logic [2:0]  frame_kind;
        logic        retry_bit;
        logic [6:0]  seq_number;
        logic [15:0] device_id;
        logic [15:0] impulses;
        logic [31:0] total_impulses;
        logic [15:0] meter_constant;
        logic [15:0] status;
        logic [15:0] power;
        logic [15:0] checksum_residue;
    } result_t;

endpackage

FILE: sv/emfd_descrambler.sv
// ----------------------------------------------------------------------------
// Energy meter frame descrambler: byte descrambler and payload store
// Removes the chained salt from all bytes but the last three, keeps the
// running byte sum and position, stores the descrambled bytes and presents
// the frame as it stands after the current byte is written.
// ----------------------------------------------------------------------------
module emfd_descrambler
    import emfd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        byte_fire,
    input  logic [7:0]  data_byte,
    input  logic [4:0]  payload_len,
    input  logic        last,
    output frame_view_t frame_view
);

    localparam int PW = $clog2(MAX_PAYLOAD + 1);
    localparam int AW = $clog2(MAX_PAYLOAD);
    localparam int CW = ((PW > 5) ? PW : 5) + 1;

    byte_t             salt_reg, salt_next;
    logic [15:0]       sum_reg, sum_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic              ovf_reg, ovf_next;
    byte_t             prev_reg;
    byte_t             store_reg [MAX_PAYLOAD];
    byte_t             dec;
    logic              room;
    logic [CW-1:0]     pos_ext, len_ext;

    assign pos_ext = CW'(pos_reg);
    assign len_ext = CW'(payload_len);
    assign room    = (pos_reg < PW'(MAX_PAYLOAD));

    always_comb begin
        salt_next = salt_reg;
        sum_next  = sum_reg;
        dec       = data_byte;
        priority if (pos_ext + CW'(3) < len_ext) begin
            dec       = data_byte ^ salt_reg;
            sum_next  = sum_reg + {8'h00, data_byte};
            salt_next = data_byte + SALT_STEP;
        end else if (pos_ext + CW'(3) == len_ext) begin
            dec      = data_byte ^ TAIL_MASK;
            sum_next = sum_reg + {8'h00, data_byte};
        end
        pos_next = room ? pos_reg + PW'(1) : pos_reg;
        ovf_next = ovf_reg | ~room;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            salt_reg <= SALT_INIT;
            sum_reg  <= '0;
            pos_reg  <= '0;
            ovf_reg  <= 1'b0;
        end else if (byte_fire) begin
            if (last) begin
                salt_reg <= SALT_INIT;
                sum_reg  <= '0;
                pos_reg  <= '0;
                ovf_reg  <= 1'b0;
            end else begin
                salt_reg <= salt_next;
                sum_reg  <= sum_next;
                pos_reg  <= pos_next;
                ovf_reg  <= ovf_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (byte_fire) begin
            prev_reg <= dec;
            if (room) begin
                store_reg[pos_reg[AW-1:0]] <= dec;
            end
        end
    end

    // In a well-formed frame the last byte sits at length minus one and the
    // byte before it at length minus two, so the checksum needs no store read.
    always_comb begin
        for (int k = 0; k < HDR_BYTES; k++) begin
            frame_view.hdr[k] = (pos_reg == PW'(k)) ? dec : store_reg[k];
        end
        frame_view.chk_hi    = prev_reg;
        frame_view.chk_lo    = dec;
        frame_view.byte_sum  = sum_reg;
        frame_view.length_ok = ((payload_len == LEN_SHORT) || (payload_len == LEN_LONG))
                               && (len_ext <= CW'(MAX_PAYLOAD))
                               && !ovf_next
                               && (CW'(pos_next) == len_ext);
    end

endmodule

FILE: sv/emfd_field_decoder.sv
// ----------------------------------------------------------------------------
// Energy meter frame descrambler: field decoder
// Checks the checksum residue, selects the frame format and extracts the
// meter fields from the descrambled frame.
// ----------------------------------------------------------------------------
module emfd_field_decoder
    import emfd_pkg::*;
(
    input  frame_view_t frame_view,
    output result_t     result
);

    logic [15:0]           residue;
    byte_t [HDR_BYTES-1:0] b;

    assign b       = frame_view.hdr;
    assign residue = {frame_view.chk_hi, frame_view.chk_lo} - frame_view.byte_sum;

    always_comb begin
        result = '0;
        priority if (!frame_view.length_ok) begin
            result.frame_kind = KIND_BAD_LEN;
        end else if (residue == RES_FIRST) begin
            result.checksum_residue = residue;
            result.retry_bit        = b[0][7];
            result.seq_number       = b[0][6:0];
            result.device_id        = {b[1], b[2]};
            result.impulses         = {b[9], b[10]};
            result.total_impulses   = {b[5], b[6], b[7], b[8]};
            result.meter_constant   = {b[14], b[15] ^ b[1]};
            priority if (b[3] == SUBTYPE_ONE) begin
                result.frame_kind = KIND_FIRST_ONE;
            end else if (b[3] == SUBTYPE_THREE) begin
                result.frame_kind = KIND_FIRST_THREE;
            end else begin
                result.frame_kind = KIND_FIRST_OTHER;
            end
        end else if (residue == RES_SECOND) begin
            result.checksum_residue = residue;
            result.frame_kind       = KIND_SECOND;
            result.retry_bit        = b[0][6];
            result.seq_number       = {1'b0, b[0][5:0]};
            result.device_id        = {b[1], b[2]};
            result.status           = {b[3], b[4]};
            result.impulses         = {b[11], b[12]};
            result.total_impulses   = {8'h00, b[8], b[9], b[10]};
            result.meter_constant   = {b[16], b[17] ^ b[1]};
            result.power            = {b[6], b[7]};
        end else begin
            result.checksum_residue = residue;
            result.frame_kind       = KIND_BAD_SUM;
        end
    end

endmodule

FILE: sv/energy_meter_frame_descrambler_unit.sv
// ----------------------------------------------------------------------------
// Energy meter frame descrambler unit
// Descrambles the payload of a meter radio frame one byte per transaction and
// delivers one decoded result transaction for each frame.
//
//   Channel | Direction | Transaction
//   s_      | in        | one payload byte with frame length and last flag
//   m_      | out       | one decoded frame, after the byte marked last
//
// One byte is taken every cycle unless a last byte waits on a held result; the
// result appears the cycle after its last byte, via the single result register.
// Reset clears the salt, sum, position and result valid; the store is not cleared.
// A non-last byte is always taken. A last byte waits only while an earlier
// result is still held and not being taken.
// ----------------------------------------------------------------------------
module energy_meter_frame_descrambler_unit
    import emfd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic [4:0]  s_payload_len,
    input  logic        s_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_frame_kind,
    output logic        m_retry_bit,
    output logic [6:0]  m_seq_number,
    output logic [15:0] m_device_id,
    output logic [15:0] m_impulses,
    output logic [31:0] m_total_impulses,
    output logic [15:0] m_meter_constant,
    output logic [15:0] m_status,
    output logic [15:0] m_power,
    output logic [15:0] m_checksum_residue
);

    frame_view_t frame_view;
    result_t     result;
    result_t     out_reg;
    logic        m_valid_reg;
    logic        byte_fire;

    assign s_ready   = !s_last || !m_valid_reg || m_ready;
    assign byte_fire = s_valid && s_ready;

    emfd_descrambler #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_descrambler (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_fire   (byte_fire),
        .data_byte   (s_data_byte),
        .payload_len (s_payload_len),
        .last        (s_last),
        .frame_view  (frame_view)
    );

    emfd_field_decoder u_decoder (
        .frame_view (frame_view),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (byte_fire && s_last) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (byte_fire && s_last) begin
            out_reg <= result;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_frame_kind       = out_reg.frame_kind;
    assign m_retry_bit        = out_reg.retry_bit;
    assign m_seq_number       = out_reg.seq_number;
    assign m_device_id        = out_reg.device_id;
    assign m_impulses         = out_reg.impulses;
    assign m_total_impulses   = out_reg.total_impulses;
    assign m_meter_constant   = out_reg.meter_constant;
    assign m_status           = out_reg.status;
    assign m_power            = out_reg.power;
    assign m_checksum_residue = out_reg.checksum_residue;

    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_fire && s_last |=> m_valid)
        else $error("accepted last byte did not produce a result");

    a_bad_len_no_residue: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_frame_kind == KIND_BAD_LEN) |-> (m_checksum_residue == 16'h0000))
        else $error("bad-length result carries a residue");

    a_first_residue: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_frame_kind == KIND_FIRST_ONE) || (m_frame_kind == KIND_FIRST_THREE)
                    || (m_frame_kind == KIND_FIRST_OTHER))
        |-> (m_checksum_residue == RES_FIRST))
        else $error("first-format result with wrong residue");

    a_second_only_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_frame_kind != KIND_SECOND) |-> (m_status == 16'h0000)
                                                     && (m_power == 16'h0000))
        else $error("status or power set outside the second format");

endmodule
